// ===== rtl/cbt_pkg.sv =====
package cbt_pkg;

  // Bitmap geometry
  localparam int unsigned WordBits       = 64;
  localparam int unsigned WordSelW       = 6;
  localparam int unsigned MapBitsDefault = 65536;

  // Request limits and sector size
  localparam int unsigned MaxReqSectors = 2048;
  localparam int unsigned SectorShift   = 9;

  // Grain shift range
  localparam logic [4:0] ShiftMin        = 5'd9;
  localparam logic [4:0] ShiftMax        = 5'd16;
  localparam logic [4:0] GrainShiftReset = 5'd9;

  // Sector index of the request end, one bit wider than start_sector
  localparam int unsigned IdxW = 33;

  // Register map
  localparam logic RegGrainShift = 1'b0;

  // Request direction codes
  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] start_sector;
    logic [11:0] sector_count;
    logic        from_client;
    logic        link_up;
  } req_t;

  typedef struct packed {
    logic route;
    logic all_marked;
  } res_t;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StPrep,
    StCheck,
    StRead,
    StModify
  } state_e;

endpackage

// ===== rtl/cbt_ram.sv =====
module cbt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic             we_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write on enable, register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/changed_block_tracker_router_unit.sv =====
// Changed-block tracker and request router. A request is taken when start is high and busy
// is low; its routing word appears on res_o for exactly one cycle with res_valid_o high,
// and the receiver cannot stall it. A request passes a prep state that computes its bit
// range and a check state that classifies it, then a read state and a modify state for each
// covered 64-bit bitmap word (read, then modify and write back through the single port of
// the bitmap RAM), with busy high throughout; requests that touch no word finish in the
// check state, and a read stops at the first word with a clear covered bit. busy drops in
// the cycle the result is shown, so the next request can be taken at the end of that cycle;
// a new request is not taken while one is in flight. After reset all ceil(MapBits/64) words
// of the bitmap RAM (1024 by default) are swept to zero, one word a cycle, with busy held
// high; grain_shift can be written during the sweep.
module changed_block_tracker_router_unit #(
  parameter int unsigned MapBits = cbt_pkg::MapBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // request channel
  input  logic          start,
  input  cbt_pkg::req_t req_i,
  output logic          busy,
  // result channel
  output logic          res_valid_o,
  output cbt_pkg::res_t res_o
);

  localparam int unsigned MapWords = (MapBits + cbt_pkg::WordBits - 1) / cbt_pkg::WordBits;
  localparam int unsigned AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned IdxW     = cbt_pkg::IdxW;
  localparam int unsigned WselW    = cbt_pkg::WordSelW;
  localparam int unsigned WordBits = cbt_pkg::WordBits;

  cbt_pkg::state_e state_q, state_d;

  logic [4:0]          shift_q, shift_d;
  logic [AddrW-1:0]    clr_q, clr_d;
  logic [AddrW-1:0]    cur_q, cur_d;
  cbt_pkg::req_t       req_q, req_d;
  logic [IdxW-1:0]     first_q, first_d;
  logic [IdxW-1:0]     last_q, last_d;
  logic                any_q, any_d;
  logic                res_valid_q, res_valid_d;
  cbt_pkg::res_t       res_q, res_d;

  logic                cfg_we;
  logic [2:0]          sh_off;
  logic [11:0]         cnt_eff;
  logic [IdxW-1:0]     end_sector;
  logic [AddrW-1:0]    first_word;
  logic [AddrW-1:0]    last_word;
  logic [WordBits-1:0] lo_mask;
  logic [WordBits-1:0] hi_mask;
  logic [WordBits-1:0] mask;
  logic [WordBits-1:0] ram_rdata;
  logic [WordBits-1:0] ram_wdata;
  logic [AddrW-1:0]    ram_addr;
  logic                ram_we;
  logic                hit;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == cbt_pkg::RegGrainShift);
  assign prdata = (paddr[2] == cbt_pkg::RegGrainShift) ? {27'd0, shift_q} : 32'd0;
  assign shift_d = cfg_we ? pwdata[4:0] : shift_q;

  // Clamp the grain shift and express it as a shift on sector indexes
  always_comb begin
    if (shift_q < cbt_pkg::ShiftMin) begin
      sh_off = 3'd0;
    end else if (shift_q > cbt_pkg::ShiftMax) begin
      sh_off = 3'(cbt_pkg::ShiftMax - cbt_pkg::ShiftMin);
    end else begin
      sh_off = 3'(shift_q - cbt_pkg::ShiftMin);
    end
  end

  // Clamp the sector count and find the last sector of the request
  assign cnt_eff = (32'(req_q.sector_count) > 32'(cbt_pkg::MaxReqSectors)) ?
                   12'(cbt_pkg::MaxReqSectors) : req_q.sector_count;
  assign end_sector = {1'b0, req_q.start_sector} + IdxW'(cnt_eff) - IdxW'(1);

  // Word addresses and covered-bit mask of the current word
  assign first_word = first_q[AddrW+WselW-1:WselW];
  assign last_word  = last_q[AddrW+WselW-1:WselW];
  assign lo_mask = (cur_q == first_word) ? ({WordBits{1'b1}} << first_q[WselW-1:0]) :
                                           {WordBits{1'b1}};
  assign hi_mask = (cur_q == last_word) ?
                   ({WordBits{1'b1}} >> (WselW'(WordBits - 1) - last_q[WselW-1:0])) :
                   {WordBits{1'b1}};
  assign mask = lo_mask & hi_mask;
  assign hit  = (ram_rdata & mask) == mask;

  // Bitmap RAM port: sweep during clear, read-modify-write otherwise
  assign ram_addr  = (state_q == cbt_pkg::StClear) ? clr_q : cur_q;
  assign ram_we    = (state_q == cbt_pkg::StClear) ||
                     ((state_q == cbt_pkg::StModify) && (req_q.cmd == cbt_pkg::CmdWrite));
  assign ram_wdata = (state_q == cbt_pkg::StClear) ? '0 :
                     req_q.from_client ? (ram_rdata & ~mask) : (ram_rdata | mask);

  cbt_ram #(
    .Width(WordBits),
    .Depth(MapWords)
  ) u_map (
    .clk_i  (clk_i),
    .addr_i (ram_addr),
    .we_i   (ram_we),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign busy = (state_q != cbt_pkg::StIdle);

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    req_d       = req_q;
    first_d     = first_q;
    last_d      = last_q;
    any_d       = any_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      cbt_pkg::StClear: begin
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MapWords - 1)) begin
          state_d = cbt_pkg::StIdle;
        end
      end
      cbt_pkg::StIdle: begin
        if (start) begin
          req_d   = req_i;
          state_d = cbt_pkg::StPrep;
        end
      end
      cbt_pkg::StPrep: begin
        // Grain index of the first and last covered sectors
        first_d = {1'b0, req_q.start_sector} >> sh_off;
        last_d  = end_sector >> sh_off;
        any_d   = (cnt_eff != 12'd0);
        state_d = cbt_pkg::StCheck;
      end
      cbt_pkg::StCheck: begin
        cur_d   = first_word;
        state_d = cbt_pkg::StRead;
        if (!req_q.link_up || (req_q.from_client && (req_q.cmd == cbt_pkg::CmdRead))) begin
          // Pass through, map untouched
          res_valid_d = 1'b1;
          res_d       = '{route: 1'b0, all_marked: 1'b0};
          state_d     = cbt_pkg::StIdle;
        end else if (!any_q) begin
          // Empty request: writes and reads resolve with no bits to walk
          res_valid_d = 1'b1;
          res_d.route = !req_q.from_client;
          res_d.all_marked = (req_q.cmd == cbt_pkg::CmdRead);
          state_d     = cbt_pkg::StIdle;
        end else if (req_q.cmd == cbt_pkg::CmdWrite) begin
          // Drop bits beyond the map
          if (first_q >= IdxW'(MapBits)) begin
            res_valid_d = 1'b1;
            res_d       = '{route: !req_q.from_client, all_marked: 1'b0};
            state_d     = cbt_pkg::StIdle;
          end else if (last_q >= IdxW'(MapBits)) begin
            last_d = IdxW'(MapBits - 1);
          end
        end else if (last_q >= IdxW'(MapBits)) begin
          // A covered bit beyond the map reads as clear
          res_valid_d = 1'b1;
          res_d       = '{route: 1'b0, all_marked: 1'b0};
          state_d     = cbt_pkg::StIdle;
        end
      end
      cbt_pkg::StRead: begin
        state_d = cbt_pkg::StModify;
      end
      cbt_pkg::StModify: begin
        if ((req_q.cmd == cbt_pkg::CmdRead) && !hit) begin
          res_valid_d = 1'b1;
          res_d       = '{route: 1'b0, all_marked: 1'b0};
          state_d     = cbt_pkg::StIdle;
        end else if (cur_q == last_word) begin
          res_valid_d = 1'b1;
          if (req_q.cmd == cbt_pkg::CmdRead) begin
            res_d = '{route: 1'b1, all_marked: 1'b1};
          end else begin
            res_d = '{route: !req_q.from_client, all_marked: 1'b0};
          end
          state_d = cbt_pkg::StIdle;
        end else begin
          cur_d   = cur_q + AddrW'(1);
          state_d = cbt_pkg::StRead;
        end
      end
      default: begin
        state_d = cbt_pkg::StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbt_pkg::StClear;
      shift_q     <= cbt_pkg::GrainShiftReset;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      shift_q     <= shift_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Request and walk registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    req_q   <= req_d;
    first_q <= first_d;
    last_q  <= last_d;
    any_q   <= any_d;
    res_q   <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // A result word never shows in consecutive cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("result strobe held for two cycles");

  // A taken request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

  // A marked read always goes remote
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.all_marked) |-> res_q.route)
    else $error("all_marked without remote route");

  // The word walk never runs past the last covered word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbt_pkg::StModify) |-> (cur_q <= last_word))
    else $error("bitmap walk past last word");

  // Results only come out when the block returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (state_q == cbt_pkg::StIdle))
    else $error("result shown while still busy");
`endif

endmodule

// ===== tb/tb_changed_block_tracker_router_unit.sv =====
module tb_changed_block_tracker_router_unit;
  import cbt_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int TimeoutCycles = 400000;
  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 116;
  localparam int DrainCycles   = 80;

  // One row of the directed table: request, whether the word is typed in, typed word
  typedef struct packed {
    req_t item;
    logic typed;
    res_t want;
  } row_t;

  // Outstanding request with the routing word it must produce
  typedef struct {
    req_t item;
    res_t want;
  } pending_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start   = 1'b0;
  req_t        req_i   = '0;
  logic        busy;
  logic        res_valid_o;
  res_t        res_o;

  // Shadow copy of the dirty bitmap and of the grain_shift register
  bit          dirty_copy [MapBitsDefault];
  logic [4:0]  grain_shift_copy = GrainShiftReset;

  pending_t    pending_routes [$];
  row_t        steps [$];
  int unsigned mismatch_count = 0;
  int unsigned issued_count   = 0;
  int unsigned results_seen   = 0;
  int unsigned remote_count   = 0;
  int unsigned marked_count   = 0;
  pending_t    oldest;

  changed_block_tracker_router_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("timeout after %0d cycles, %0d words still outstanding", TimeoutCycles,
             pending_routes.size());
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Clamp the programmed grain shift to the range the block honors
  function automatic logic [4:0] active_shift();
    if (grain_shift_copy < ShiftMin) return ShiftMin;
    if (grain_shift_copy > ShiftMax) return ShiftMax;
    return grain_shift_copy;
  endfunction

  // Route one request against the shadow bitmap and update it
  function automatic res_t route_request(input req_t item);
    logic [63:0] count;
    logic [63:0] first_grain;
    logic [63:0] last_grain;
    logic [63:0] g;
    logic [4:0]  sh;
    res_t        res;
    sh = active_shift();
    count = (item.sector_count > MaxReqSectors) ? 64'(MaxReqSectors)
                                                : 64'(item.sector_count);
    res = '0;
    first_grain = '0;
    last_grain = '0;
    if (count != 0) begin
      first_grain = (64'(item.start_sector) << SectorShift) >> sh;
      last_grain = (((64'(item.start_sector) + count) << SectorShift) - 64'd1) >> sh;
    end
    if (item.link_up) begin
      if (item.from_client) begin
        // client writes clear the covered grains, client reads just pass
        if (item.cmd == CmdWrite && count != 0)
          for (g = first_grain; g <= last_grain && g < 64'(MapBitsDefault); g++)
            dirty_copy[g] = 1'b0;
      end else if (item.cmd == CmdWrite) begin
        if (count != 0)
          for (g = first_grain; g <= last_grain && g < 64'(MapBitsDefault); g++)
            dirty_copy[g] = 1'b1;
        res.route = 1'b1;
      end else begin
        // grains past the map read as clear
        res.all_marked = 1'b1;
        if (count != 0)
          for (g = first_grain; g <= last_grain && res.all_marked; g++)
            if (g >= 64'(MapBitsDefault) || !dirty_copy[g]) res.all_marked = 1'b0;
        res.route = res.all_marked;
      end
    end
    return res;
  endfunction

  // Present a request, hold it until taken, then log the word it must produce
  task automatic issue_request(input req_t item, input logic typed, input res_t want);
    pending_t entry;
    res_t     predicted;
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = route_request(item);
    entry.item = item;
    entry.want = typed ? want : predicted;
    pending_routes.push_back(entry);
    issued_count++;
  endtask

  // One APB transfer: setup, access until pready, then return the bus to idle
  task automatic apb_transfer(input logic is_write, input logic [2:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Program grain_shift and read it back
  task automatic set_grain_shift(input logic [4:0] value);
    logic [31:0] rdata;
    apb_transfer(1'b1, {RegGrainShift, 2'b00}, {27'd0, value}, rdata);
    grain_shift_copy = value;
    apb_transfer(1'b0, {RegGrainShift, 2'b00}, '0, rdata);
    if (rdata !== {27'd0, value})
      report_mismatch($sformatf("grain_shift read back %0h, wrote %0h", rdata, value));
  endtask

  // Check every result word against the oldest outstanding request
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) begin
      results_seen++;
      if (res_o.route === 1'b1) remote_count++;
      if (res_o.all_marked === 1'b1) marked_count++;
      if (pending_routes.size() == 0) begin
        report_mismatch($sformatf("result word %b with no request outstanding", res_o));
      end else begin
        oldest = pending_routes.pop_front();
        if (res_o.route !== oldest.want.route)
          report_mismatch($sformatf("route %b, want %b for request %h",
                                    res_o.route, oldest.want.route, oldest.item));
        if (res_o.all_marked !== oldest.want.all_marked)
          report_mismatch($sformatf("all_marked %b, want %b for request %h",
                                    res_o.all_marked, oldest.want.all_marked, oldest.item));
      end
    end
  end

  initial begin
    logic [4:0]  plan [NumPhases];
    logic [31:0] hot_base [4];
    logic [31:0] rdata;
    logic [63:0] span;
    int unsigned grain_sectors;
    int unsigned roll;
    logic        last_in_phase;
    req_t        item;
    req_t        last_write;

    plan = '{5'd16, 5'd0, 5'd31, 5'd12, 5'd9, 5'd14, 5'd10, 5'd11};
    plan[5] = 5'($urandom_range(0, 31));
    last_write = '0;

    // Directed rows: cmd, start, count, client, link | typed, route, all_marked
    steps.push_back({CmdRead,  32'd0,          12'd1,    1'b0, 1'b1, 1'b1, 1'b0, 1'b0});
    // empty read from the far side goes remote fully marked
    steps.push_back({CmdRead,  32'd0,          12'd0,    1'b0, 1'b1, 1'b1, 1'b1, 1'b1});
    steps.push_back({CmdWrite, 32'd0,          12'd8,    1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    steps.push_back({CmdWrite, 32'd0,          12'd8,    1'b0, 1'b1, 1'b1, 1'b1, 1'b0});
    steps.push_back({CmdRead,  32'd0,          12'd8,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    steps.push_back({CmdRead,  32'd0,          12'd8,    1'b1, 1'b1, 1'b1, 1'b0, 1'b0});
    steps.push_back({CmdWrite, 32'd2,          12'd1,    1'b1, 1'b1, 1'b1, 1'b0, 1'b0});
    steps.push_back({CmdRead,  32'd0,          12'd8,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    // straddle the end of the map
    steps.push_back({CmdWrite, 32'd65535,      12'd2,    1'b0, 1'b1, 1'b1, 1'b1, 1'b0});
    steps.push_back({CmdRead,  32'd65535,      12'd1,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    steps.push_back({CmdRead,  32'd65535,      12'd2,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    // top sector with an oversized count
    steps.push_back({CmdWrite, 32'hFFFF_FFFF,  12'hFFF,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0});
    steps.push_back({CmdRead,  32'hFFFF_FFFF,  12'hFFF,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    steps.push_back({CmdWrite, 32'd100,        12'd2048, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0});
    steps.push_back({CmdRead,  32'd100,        12'd2048, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    steps.push_back({CmdRead,  32'd100,        12'd3000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    steps.push_back({CmdRead,  32'd99,         12'd2,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    steps.push_back({CmdWrite, 32'd200,        12'hFFF,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0});
    steps.push_back({CmdRead,  32'd100,        12'd2048, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    steps.push_back({CmdWrite, 32'd5000,       12'd10,   1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    steps.push_back({CmdRead,  32'd5000,       12'd10,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    steps.push_back({CmdWrite, 32'd7,          12'd0,    1'b1, 1'b1, 1'b1, 1'b0, 1'b0});
    steps.push_back({CmdWrite, 32'd7,          12'd0,    1'b0, 1'b1, 1'b1, 1'b1, 1'b0});
    steps.push_back({CmdRead,  32'd7,          12'd0,    1'b1, 1'b1, 1'b1, 1'b0, 1'b0});
    steps.push_back({CmdRead,  32'd7,          12'd0,    1'b0, 1'b0, 1'b1, 1'b0, 1'b0});

    // Hold reset, then check the reset value of grain_shift during the sweep
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_transfer(1'b0, {RegGrainShift, 2'b00}, '0, rdata);
    if (rdata !== {27'd0, GrainShiftReset})
      report_mismatch($sformatf("grain_shift reset value %0h", rdata));

    // Walk the directed table back to back
    foreach (steps[i]) issue_request(steps[i].item, steps[i].typed, steps[i].want);
    start <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk_i);

    for (int phase = 0; phase < NumPhases; phase++) begin
      set_grain_shift(plan[phase]);
      grain_sectors = 1 << (active_shift() - SectorShift);
      span = 64'(MapBitsDefault) << (active_shift() - SectorShift);
      for (int h = 0; h < 3; h++) hot_base[h] = $urandom_range(0, 32'(span / 2));
      hot_base[3] = 32'(span) - 32'(4 * grain_sectors);

      for (int k = 0; k < PhaseItems; k++) begin
        roll = $urandom_range(0, 99);
        item.cmd = 1'($urandom_range(0, 1));
        item.from_client = ($urandom_range(0, 6) == 0);
        item.link_up = ($urandom_range(0, 9) != 0);
        if (roll < 65) begin
          // hot spots: writes and reads over the same few regions
          if (item.cmd == CmdRead && !item.from_client && $urandom_range(0, 1) == 1) begin
            item.start_sector = last_write.start_sector;
            item.sector_count = last_write.sector_count;
          end else begin
            item.start_sector = hot_base[$urandom_range(0, 3)]
                                + $urandom_range(0, 6 * grain_sectors + 32);
            item.sector_count = ($urandom_range(0, 7) == 0)
                                ? 12'($urandom_range(0, 2048))
                                : 12'($urandom_range(1, 3 * grain_sectors + 16));
          end
        end else if (roll < 80) begin
          item.start_sector = $urandom_range(0, 32'(span - 1));
          item.sector_count = 12'($urandom_range(0, 2048));
        end else if (roll < 88) begin
          // around the end of the map
          item.start_sector = 32'(span) - $urandom_range(1, 3 * grain_sectors + 8);
          item.sector_count = 12'($urandom_range(1, 6 * grain_sectors + 16));
        end else begin
          item.start_sector = $urandom();
          item.sector_count = 12'($urandom_range(0, 4095));
        end
        if (item.cmd == CmdWrite && !item.from_client && item.link_up) last_write = item;

        issue_request(item, 1'b0, '0);

        // Drop start at the end of a phase, or idle now and then outside the quiet stretch
        last_in_phase = (k == PhaseItems - 1);
        if (last_in_phase ||
            (!(issued_count >= 300 && issued_count < 500) && $urandom_range(0, 99) < 6)) begin
          start <= 1'b0;
          if (!last_in_phase) repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
      while (pending_routes.size() != 0) @(posedge clk_i);
    end

    // Let any stray word show up before closing
    repeat (DrainCycles) @(posedge clk_i);
    $display("Routed %0d requests (%0d directed) over %0d grain_shift settings, 0 and 31 included.",
             issued_count, steps.size(), NumPhases + 1);
    $display("%0d words went remote, %0d reads found every covered grain marked.",
             remote_count, marked_count);
    if (mismatch_count == 0 && results_seen == issued_count) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
